// ===== rtl/tms_pkg.sv =====
package tms_pkg;

   // tape, rule table and column sizes
   localparam int TAPE_CELLS = 64;
   localparam int STATES     = 16;
   localparam int SYMBOLS    = 4;

   localparam int TAPE_AW    = $clog2(TAPE_CELLS);
   localparam int RULE_AW    = $clog2(STATES * SYMBOLS);
   localparam int COL_W      = $clog2(SYMBOLS);
   localparam int SCNT_W     = 3;
   localparam int CHAR_W     = 8;
   localparam int STATE_W    = 4;
   localparam int POS_W      = 6;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_SYMBOL = 1'b1;

   // register reset values
   localparam logic [SCNT_W-1:0] SYMBOL_COUNT_RESET = 3'd4;
   localparam logic [CHAR_W-1:0] BLANK_RESET        = 8'd42;

   typedef enum logic [2:0] {
      CMD_CLEAR     = 3'd0,
      CMD_WR_COLUMN = 3'd1,
      CMD_WR_RULE   = 3'd2,
      CMD_WR_TAPE   = 3'd3,
      CMD_STEP      = 3'd4,
      CMD_RD_TAPE   = 3'd5
   } command_type;

   typedef enum logic [1:0] {
      MOVE_NONE  = 2'd0,
      MOVE_LEFT  = 2'd1,
      MOVE_RIGHT = 2'd2
   } move_type;

   typedef enum logic [1:0] {
      FAULT_NONE   = 2'd0,
      FAULT_SYMBOL = 2'd1,
      FAULT_TAPE   = 2'd2
   } fault_type;

   // one rule table entry
   typedef struct packed {
      logic               halt;
      logic [STATE_W-1:0] next_state;
      logic [1:0]         move;
      logic [CHAR_W-1:0]  symbol;
   } rule_type;

endpackage

// ===== rtl/turing_machine_stepper_unit.sv =====
// Single-tape Turing machine. Each request transaction carries one command:
// clear, write column, write rule, write tape cell, step, or read tape cell.
// Every command returns exactly one response transaction with the machine
// state, head position, halt flag, fault code and a read character.
// The block works on one command at a time; req_ready is high only when the
// sequencer is idle. States passed after a request is accepted:
//   clear, column, rule, tape write, unused codes: decode, finish
//   tape read, step while halted or with no active columns: decode,
//   tape read, finish
//   step: decode, tape read, match at one column character tried per cycle,
//   apply the rule on a match, finish
// The response turns valid as the sequencer goes back to idle.
// Column matching uses one shared 8-bit comparator, stepped by a column
// counter; tape and rule table are memories with registered reads.
// The response sits in an output register; the next request is taken while
// it waits. If rsp_ready stays low the sequencer holds the following result
// in its final state until the register frees up.
// Reset clears head, state, halt and fault and leaves every tape cell reading
// as the blank character 42 (per-cell valid bits, no sweep). Clear does the
// same with the programmed blank character.
module turing_machine_stepper_unit
   import tms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_command,
   input  logic [STATE_W-1:0]    req_state_index,
   input  logic [1:0]            req_column_index,
   input  logic [POS_W-1:0]      req_position,
   input  logic [CHAR_W-1:0]     req_symbol_char,
   input  logic [1:0]            req_move,
   input  logic [STATE_W-1:0]    req_next_state,
   input  logic                  req_halt_next,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATE_W-1:0]    rsp_machine_state,
   output logic [POS_W-1:0]      rsp_head_position,
   output logic [CHAR_W-1:0]     rsp_read_char,
   output logic                  rsp_halted,
   output logic [1:0]            rsp_fault
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TAPE_RD,
      ST_MATCH,
      ST_APPLY,
      ST_FINISH
   } state_type;

   state_type            state_ff;

   // configuration registers
   logic [SCNT_W-1:0]    symbol_count_ff;
   logic [CHAR_W-1:0]    blank_symbol_ff;

   // latched request
   logic [2:0]           cmd_ff;
   logic [STATE_W-1:0]   sidx_ff;
   logic [1:0]           cidx_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [CHAR_W-1:0]    sym_ff;
   logic [1:0]           move_ff;
   logic [STATE_W-1:0]   nstate_ff;
   logic                 hnext_ff;

   // machine state
   logic [TAPE_AW-1:0]   head_ff;
   logic [STATE_W-1:0]   mstate_ff;
   logic                 halt_ff;
   fault_type            fault_ff;

   // tape: memory plus valid bits; invalid cells read as fill_char_ff
   logic [CHAR_W-1:0]    tape_mem [TAPE_CELLS];
   logic [TAPE_CELLS-1:0] tape_vld_ff;
   logic [CHAR_W-1:0]    fill_char_ff;
   logic [CHAR_W-1:0]    tape_q_ff;
   logic                 tape_hit_ff;

   logic [CHAR_W-1:0]    column_chars_ff [SYMBOLS];

   // rule table
   logic [RULE_AW+1+STATE_W+2+CHAR_W-RULE_AW-1:0] rule_mem [STATES*SYMBOLS];
   rule_type             rule_q_ff;
   logic                 rule_ok_ff;

   // sequencer working registers
   logic [COL_W-1:0]     col_cnt_ff;
   logic [CHAR_W-1:0]    cell_ff;
   logic [CHAR_W-1:0]    rd_ff;

   // response register
   logic                 rsp_valid_ff;
   logic [STATE_W-1:0]   rsp_state_ff;
   logic [TAPE_AW-1:0]   rsp_head_ff;
   logic [CHAR_W-1:0]    rsp_char_ff;
   logic                 rsp_halt_ff;
   fault_type            rsp_fault_ff;
   logic                 rsp_load;

   logic [SCNT_W-1:0]    n_eff;
   logic [CHAR_W-1:0]    cell_char;
   logic                 col_hit;
   logic                 col_last;
   logic                 pos_ok;
   logic                 state_ok;
   rule_type             rule_eff;
   logic [TAPE_AW-1:0]   head_in;
   logic                 head_fault;

   logic                 tape_we;
   logic [TAPE_AW-1:0]   tape_waddr;
   logic [CHAR_W-1:0]    tape_wdata;
   logic [TAPE_AW-1:0]   tape_raddr;
   logic                 rule_we;
   logic [RULE_AW-1:0]   rule_waddr;
   logic [RULE_AW-1:0]   rule_raddr;
   rule_type             rule_wdata;

   // active column count, clipped to the column table size
   assign n_eff = (int'(symbol_count_ff) > SYMBOLS) ? SCNT_W'(SYMBOLS) : symbol_count_ff;

   assign cell_char = tape_hit_ff ? tape_q_ff : fill_char_ff;
   assign pos_ok    = int'(pos_ff) < TAPE_CELLS;
   assign state_ok  = int'(mstate_ff) < STATES;

   // shared column comparator
   assign col_hit  = (column_chars_ff[col_cnt_ff] == cell_ff);
   assign col_last = (SCNT_W'(col_cnt_ff) + SCNT_W'(1)) >= n_eff;

   assign rule_eff = rule_ok_ff ? rule_q_ff : '0;

   // response register loads when finishing and the register is free
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // head move and edge check
   always_comb begin
      head_in    = head_ff;
      head_fault = 1'b0;
      unique case (move_type'(rule_eff.move))
         MOVE_LEFT: begin
            if (head_ff == '0) head_fault = 1'b1;
            else head_in = head_ff - TAPE_AW'(1);
         end
         MOVE_RIGHT: begin
            if (int'(head_ff) + 1 >= TAPE_CELLS) head_fault = 1'b1;
            else head_in = head_ff + TAPE_AW'(1);
         end
         default: begin
            head_in = head_ff;
         end
      endcase
   end

   // memory port selection
   always_comb begin
      tape_we    = 1'b0;
      tape_waddr = pos_ff[TAPE_AW-1:0];
      tape_wdata = sym_ff;
      if (state_ff == ST_DECODE && cmd_ff == CMD_WR_TAPE && pos_ok) begin
         tape_we = 1'b1;
      end else if (state_ff == ST_APPLY) begin
         tape_we    = 1'b1;
         tape_waddr = head_ff;
         tape_wdata = rule_eff.symbol;
      end
   end

   assign tape_raddr = (cmd_ff == CMD_STEP) ? head_ff : pos_ff[TAPE_AW-1:0];

   assign rule_we    = (state_ff == ST_DECODE) && (cmd_ff == CMD_WR_RULE) &&
                       (int'(sidx_ff) < STATES) && (int'(cidx_ff) < SYMBOLS);
   assign rule_waddr = RULE_AW'(int'(sidx_ff) * SYMBOLS + int'(cidx_ff));
   assign rule_raddr = RULE_AW'(int'(mstate_ff) * SYMBOLS + int'(col_cnt_ff));
   assign rule_wdata = '{halt: hnext_ff, next_state: nstate_ff, move: move_ff, symbol: sym_ff};

   // tape memory
   always_ff @(posedge clock) begin
      if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
      tape_q_ff <= tape_mem[tape_raddr];
   end

   // rule memory
   always_ff @(posedge clock) begin
      if (rule_we) rule_mem[rule_waddr] <= rule_wdata;
      rule_q_ff <= rule_type'(rule_mem[rule_raddr]);
   end

   // sequencer, machine state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         symbol_count_ff <= SYMBOL_COUNT_RESET;
         blank_symbol_ff <= BLANK_RESET;
         fill_char_ff    <= BLANK_RESET;
         tape_vld_ff     <= '0;
         head_ff         <= '0;
         mstate_ff       <= '0;
         halt_ff         <= 1'b0;
         fault_ff        <= FAULT_NONE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // configuration writes
         if (csr_wen) begin
            unique case (csr_index)
               CSR_SYMBOL_COUNT: symbol_count_ff <= csr_wdata[SCNT_W-1:0];
               CSR_BLANK_SYMBOL: blank_symbol_ff <= csr_wdata;
               default:          symbol_count_ff <= symbol_count_ff;
            endcase
         end

         // response valid: set on a load, cleared once taken
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         // valid bit lookup alongside the tape read
         tape_hit_ff <= tape_vld_ff[tape_raddr];
         if (tape_we) tape_vld_ff[tape_waddr] <= 1'b1;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff    <= req_command;
                  sidx_ff   <= req_state_index;
                  cidx_ff   <= req_column_index;
                  pos_ff    <= req_position;
                  sym_ff    <= req_symbol_char;
                  move_ff   <= req_move;
                  nstate_ff <= req_next_state;
                  hnext_ff  <= req_halt_next;
                  state_ff  <= ST_DECODE;
               end
            end

            ST_DECODE: begin
               rd_ff <= '0;
               unique case (command_type'(cmd_ff))
                  CMD_CLEAR: begin
                     tape_vld_ff  <= '0;
                     fill_char_ff <= blank_symbol_ff;
                     head_ff      <= '0;
                     mstate_ff    <= '0;
                     halt_ff      <= 1'b0;
                     fault_ff     <= FAULT_NONE;
                     state_ff     <= ST_FINISH;
                  end
                  CMD_WR_COLUMN: begin
                     if (int'(cidx_ff) < SYMBOLS) column_chars_ff[cidx_ff[COL_W-1:0]] <= sym_ff;
                     state_ff <= ST_FINISH;
                  end
                  CMD_STEP, CMD_RD_TAPE: begin
                     state_ff <= ST_TAPE_RD;
                  end
                  default: begin
                     state_ff <= ST_FINISH;
                  end
               endcase
            end

            ST_TAPE_RD: begin
               cell_ff    <= cell_char;
               col_cnt_ff <= '0;
               if (cmd_ff == CMD_RD_TAPE) begin
                  rd_ff    <= pos_ok ? cell_char : '0;
                  state_ff <= ST_FINISH;
               end else begin
                  rd_ff <= cell_char;
                  if (!halt_ff && n_eff != '0) begin
                     state_ff <= ST_MATCH;
                  end else begin
                     state_ff <= ST_FINISH;
                     // no active columns: nothing can match
                     if (!halt_ff) begin
                        halt_ff  <= 1'b1;
                        fault_ff <= FAULT_SYMBOL;
                     end
                  end
               end
            end

            // one column per cycle; the rule read goes out on a hit
            ST_MATCH: begin
               rule_ok_ff <= state_ok;
               if (col_hit) begin
                  state_ff <= ST_APPLY;
               end else if (col_last) begin
                  halt_ff  <= 1'b1;
                  fault_ff <= FAULT_SYMBOL;
                  state_ff <= ST_FINISH;
               end else begin
                  col_cnt_ff <= col_cnt_ff + COL_W'(1);
               end
            end

            ST_APPLY: begin
               mstate_ff <= rule_eff.next_state;
               head_ff   <= head_in;
               if (rule_eff.halt || head_fault) halt_ff <= 1'b1;
               if (head_fault) fault_ff <= FAULT_TAPE;
               state_ff  <= ST_FINISH;
            end

            ST_FINISH: begin
               if (rsp_load) begin
                  rsp_state_ff <= mstate_ff;
                  rsp_head_ff  <= head_ff;
                  rsp_char_ff  <= rd_ff;
                  rsp_halt_ff  <= halt_ff;
                  rsp_fault_ff <= fault_ff;
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_machine_state = rsp_state_ff;
   assign rsp_head_position = POS_W'(rsp_head_ff);
   assign rsp_read_char     = rsp_char_ff;
   assign rsp_halted        = rsp_halt_ff;
   assign rsp_fault         = rsp_fault_ff;

   // a fault always comes with the halt flag
   assert property (@(posedge clock) disable iff (reset)
      (fault_ff != FAULT_NONE) |-> halt_ff)
      else $error("fault set without halt");

   // an accepted request always goes to decode
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECODE))
      else $error("accepted request not decoded");

   // the head only moves on a rule apply or a clear
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_APPLY && !(state_ff == ST_DECODE && cmd_ff == CMD_CLEAR))
         |=> $stable(head_ff))
      else $error("head moved outside apply or clear");

   // the column counter stays within the active columns
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH) |-> (SCNT_W'(col_cnt_ff) < n_eff))
      else $error("column counter past active columns");

   // a result is never dropped: finish waits while the response is stalled
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FINISH))
      else $error("result overwrote a pending response");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top
   import tms_pkg::*;
();

   // spare command codes: the block must answer them without any change
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   // characters used by the directed programs
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_L    = 8'h4C;
   localparam logic [7:0] CHAR_R    = 8'h52;

   localparam int ITEM_TARGET  = 750;
   localparam int IDLE_PCT     = 22;
   localparam int SETTLE_CYC   = 12;
   localparam int RUN_LIMIT    = 800000;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [POS_W-1:0]   head;
      logic [CHAR_W-1:0]  rd;
      logic               halted;
      logic [1:0]         fault;
   } status_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_command = '0;
   logic [STATE_W-1:0]    req_state_index = '0;
   logic [1:0]            req_column_index = '0;
   logic [POS_W-1:0]      req_position = '0;
   logic [CHAR_W-1:0]     req_symbol_char = '0;
   logic [1:0]            req_move = '0;
   logic [STATE_W-1:0]    req_next_state = '0;
   logic                  req_halt_next = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATE_W-1:0]    rsp_machine_state;
   logic [POS_W-1:0]      rsp_head_position;
   logic [CHAR_W-1:0]     rsp_read_char;
   logic                  rsp_halted;
   logic [1:0]            rsp_fault;

   // machine image kept by the testbench
   logic [CHAR_W-1:0]  tape_img [TAPE_CELLS];
   rule_type           rule_img [STATES*SYMBOLS];
   logic               rule_known [STATES*SYMBOLS];
   logic [CHAR_W-1:0]  col_img [SYMBOLS];
   logic               col_known [SYMBOLS];
   logic [POS_W-1:0]   head_pos;
   logic [STATE_W-1:0] mach_state;
   logic               halt_bit;
   fault_type          fault_bit;
   logic [SCNT_W-1:0]  count_reg;
   logic [CHAR_W-1:0]  blank_reg;

   // outcomes still owed by the block, oldest first
   status_type status_q [$];

   // random program shape
   logic [CHAR_W-1:0] prog_alpha [4];
   int                prog_states = 16;
   logic              steady = 1'b0;

   int mismatches = 0;
   int items_sent = 0;
   int n_steps = 0;
   int n_rule_halts = 0;
   int n_symbol_faults = 0;
   int n_edge_faults = 0;
   int n_settings = 0;

   turing_machine_stepper_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_state_index   (req_state_index),
      .req_column_index  (req_column_index),
      .req_position      (req_position),
      .req_symbol_char   (req_symbol_char),
      .req_move          (req_move),
      .req_next_state    (req_next_state),
      .req_halt_next     (req_halt_next),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_machine_state (rsp_machine_state),
      .rsp_head_position (rsp_head_position),
      .rsp_read_char     (rsp_read_char),
      .rsp_halted        (rsp_halted),
      .rsp_fault         (rsp_fault)
   );

   always #1 clock = ~clock;

   // machine image after reset
   task automatic image_reset();
      foreach (tape_img[i]) tape_img[i] = BLANK_RESET;
      foreach (rule_known[i]) rule_known[i] = 1'b0;
      foreach (col_known[i]) col_known[i] = 1'b0;
      head_pos   = '0;
      mach_state = '0;
      halt_bit   = 1'b0;
      fault_bit  = FAULT_NONE;
      count_reg  = SYMBOL_COUNT_RESET;
      blank_reg  = BLANK_RESET;
   endtask

   // apply one command to the image and return what the block must answer
   function automatic status_type advance_machine(input logic [2:0] cmd,
         input logic [3:0] si, input logic [1:0] ci, input logic [5:0] pos,
         input logic [7:0] sym, input logic [1:0] mv, input logic [3:0] ns,
         input logic hn);
      status_type res;
      rule_type   rule;
      logic [1:0] col;
      logic       hit;
      int         active;
      int         k;
      res.rd = '0;
      case (cmd)
         CMD_CLEAR: begin
            foreach (tape_img[i]) tape_img[i] = blank_reg;
            head_pos   = '0;
            mach_state = '0;
            halt_bit   = 1'b0;
            fault_bit  = FAULT_NONE;
         end
         CMD_WR_COLUMN: begin
            col_img[ci]   = sym;
            col_known[ci] = 1'b1;
         end
         CMD_WR_RULE: begin
            rule_img[{si, ci}]   = {hn, ns, mv, sym};
            rule_known[{si, ci}] = 1'b1;
         end
         CMD_WR_TAPE: tape_img[pos] = sym;
         CMD_STEP: begin
            res.rd = tape_img[head_pos];
            n_steps++;
            if (!halt_bit) begin
               active = (count_reg > SYMBOLS) ? SYMBOLS : count_reg;
               hit = 1'b0;
               col = '0;
               // scan downward so the lowest matching column wins
               for (k = active - 1; k >= 0; k--) begin
                  if (col_img[k] == res.rd) begin
                     hit = 1'b1;
                     col = k[1:0];
                  end
               end
               if (!hit) begin
                  halt_bit  = 1'b1;
                  fault_bit = FAULT_SYMBOL;
                  n_symbol_faults++;
               end else begin
                  rule = rule_img[{mach_state, col}];
                  tape_img[head_pos] = rule.symbol;
                  mach_state = rule.next_state;
                  if (rule.halt) begin
                     halt_bit = 1'b1;
                     n_rule_halts++;
                  end
                  // head stays put when the move would leave the tape
                  case (rule.move)
                     MOVE_LEFT: begin
                        if (head_pos == 0) begin
                           halt_bit  = 1'b1;
                           fault_bit = FAULT_TAPE;
                           n_edge_faults++;
                        end else begin
                           head_pos--;
                        end
                     end
                     MOVE_RIGHT: begin
                        if (head_pos == TAPE_CELLS - 1) begin
                           halt_bit  = 1'b1;
                           fault_bit = FAULT_TAPE;
                           n_edge_faults++;
                        end else begin
                           head_pos++;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         CMD_RD_TAPE: res.rd = tape_img[pos];
         default: ;
      endcase
      res.state  = mach_state;
      res.head   = head_pos;
      res.halted = halt_bit;
      res.fault  = fault_bit;
      return res;
   endfunction

   // offer one command, hold it until accepted, then record its outcome
   task automatic send_item(input logic [2:0] cmd, input logic [3:0] si,
         input logic [1:0] ci, input logic [5:0] pos, input logic [7:0] sym,
         input logic [1:0] mv, input logic [3:0] ns, input logic hn);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_state_index  <= si;
      req_column_index <= ci;
      req_position     <= pos;
      req_symbol_char  <= sym;
      req_move         <= mv;
      req_next_state   <= ns;
      req_halt_next    <= hn;
      do @(posedge clock); while (!req_ready);
      status_q.push_back(advance_machine(cmd, si, ci, pos, sym, mv, ns, hn));
      items_sent++;
   endtask

   task automatic clear_tape();
      send_item(CMD_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0);
   endtask

   task automatic wr_column(input logic [1:0] ci, input logic [7:0] ch);
      send_item(CMD_WR_COLUMN, '0, ci, '0, ch, '0, '0, 1'b0);
   endtask

   task automatic wr_rule(input logic [3:0] si, input logic [1:0] ci,
         input logic [7:0] sym, input logic [1:0] mv, input logic [3:0] ns,
         input logic hn);
      send_item(CMD_WR_RULE, si, ci, '0, sym, mv, ns, hn);
   endtask

   task automatic wr_tape(input logic [5:0] pos, input logic [7:0] ch);
      send_item(CMD_WR_TAPE, '0, '0, pos, ch, '0, '0, 1'b0);
   endtask

   task automatic rd_tape(input logic [5:0] pos);
      send_item(CMD_RD_TAPE, '0, '0, pos, '0, '0, '0, 1'b0);
   endtask

   task automatic step();
      send_item(CMD_STEP, '0, '0, '0, '0, '0, '0, 1'b0);
   endtask

   // mostly characters of the current alphabet so that columns match
   function automatic logic [7:0] pick_char();
      if ($urandom_range(99) < 85) return prog_alpha[$urandom_range(3)];
      return 8'($urandom_range(255));
   endfunction

   task automatic wr_random_rule(input logic [3:0] si, input logic [1:0] ci);
      int         r;
      logic [1:0] mv;
      r = $urandom_range(9);
      if (r == 0) mv = MOVE_NONE;
      else if (r == 1) mv = 2'd3;
      else if (r < 6) mv = MOVE_LEFT;
      else mv = MOVE_RIGHT;
      wr_rule(si, ci, pick_char(), mv, 4'($urandom_range(prog_states - 1)),
              $urandom_range(24) == 0);
   endtask

   // the next step must only touch columns and rules already written
   task automatic make_step_legal();
      int   active;
      int   i;
      logic matched;
      if (!halt_bit) begin
         active  = (count_reg > SYMBOLS) ? SYMBOLS : count_reg;
         matched = 1'b0;
         for (i = 0; i < active && !matched; i++) begin
            if (!col_known[i]) wr_column(i[1:0], pick_char());
            if (col_img[i] == tape_img[head_pos]) begin
               matched = 1'b1;
               if (!rule_known[{mach_state, i[1:0]}])
                  wr_random_rule(mach_state, i[1:0]);
            end
         end
      end
   endtask

   task automatic safe_step();
      make_step_legal();
      step();
   endtask

   task automatic send_noise();
      logic [2:0] cmd;
      cmd = 3'($urandom_range(7));
      if (cmd == CMD_STEP) make_step_legal();
      send_item(cmd, 4'($urandom_range(15)), 2'($urandom_range(3)),
                6'($urandom_range(63)), 8'($urandom_range(255)),
                2'($urandom_range(3)), 4'($urandom_range(15)),
                1'($urandom_range(1)));
   endtask

   // let the block drain before touching its registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic set_registers(input logic [2:0] cnt, input logic [7:0] blank);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_index <= CSR_SYMBOL_COUNT;
      csr_wdata <= CSR_DATA_W'(cnt);
      @(posedge clock);
      count_reg = cnt;
      csr_index <= CSR_BLANK_SYMBOL;
      csr_wdata <= blank;
      @(posedge clock);
      blank_reg = blank;
      csr_wen <= 1'b0;
      n_settings++;
   endtask

   // response checking
   task automatic compare_field(input string what, input logic [7:0] want,
         input logic [7:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      status_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               $display("%0t response transaction with nothing expected", $time);
               mismatches++;
            end else begin
               want = status_q.pop_front();
               compare_field("machine_state", 8'(want.state), 8'(rsp_machine_state));
               compare_field("head_position", 8'(want.head), 8'(rsp_head_position));
               compare_field("read_char", want.rd, rsp_read_char);
               compare_field("halted", 8'(want.halted), 8'(rsp_halted));
               compare_field("fault", 8'(want.fault), 8'(rsp_fault));
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // blank tape after reset, spare codes
   task automatic test_power_on();
      rd_tape(6'd0);
      rd_tape(6'(TAPE_CELLS - 1));
      send_item(CMD_SPARE6, 4'hF, 2'd3, 6'h3F, 8'hFF, 2'd3, 4'hF, 1'b1);
      send_item(CMD_SPARE7, '0, '0, '0, '0, '0, '0, 1'b0);
   endtask

   // two good steps, then a character no column knows, then a step while halted
   task automatic test_unknown_symbol();
      wr_column(2'd0, 8'h00);
      wr_column(2'd1, 8'hFF);
      wr_column(2'd2, CHAR_L);
      wr_column(2'd3, CHAR_STAR);
      wr_rule(4'd0, 2'd3, CHAR_R, MOVE_RIGHT, 4'd1, 1'b0);
      wr_rule(4'd1, 2'd3, 8'hFF, MOVE_LEFT, 4'd15, 1'b0);
      step();
      step();
      step();
      step();
   endtask

   // halt by rule, then a move left off cell zero
   task automatic test_halt_and_left_edge();
      set_registers(3'd4, 8'h00);
      clear_tape();
      wr_rule(4'd0, 2'd0, CHAR_L, MOVE_NONE, 4'd5, 1'b1);
      step();
      wr_rule(4'd0, 2'd0, 8'hFF, MOVE_LEFT, 4'd15, 1'b0);
      clear_tape();
      step();
      step();
      wr_tape(6'(TAPE_CELLS - 1), 8'hA5);
      rd_tape(6'(TAPE_CELLS - 1));
   endtask

   // walk right across the whole tape until the head would fall off the end
   task automatic test_tape_end();
      set_registers(3'd1, 8'hFF);
      wr_column(2'd0, 8'hFF);
      clear_tape();
      wr_rule(4'd0, 2'd0, 8'($urandom_range(255)), MOVE_RIGHT, 4'd0, 1'b0);
      while (!halt_bit) step();
      step();
   endtask

   // one short program: alphabet, optional clear, table edits, then a run
   task automatic run_program();
      int active;
      int n_run;
      int k;
      int r;
      logic stop;
      active = (count_reg > SYMBOLS) ? SYMBOLS : count_reg;
      foreach (prog_alpha[i]) prog_alpha[i] = 8'($urandom_range(255));
      if ($urandom_range(3) != 0)
         prog_alpha[(active == 0) ? $urandom_range(3) : $urandom_range(active - 1)] = blank_reg;
      prog_states = $urandom_range(1, STATES);
      if ($urandom_range(4) != 0) clear_tape();
      for (k = 0; k < SYMBOLS; k++)
         if ($urandom_range(9) < 7) wr_column(k[1:0], prog_alpha[k]);
      repeat ($urandom_range(0, 4))
         wr_random_rule(4'($urandom_range(prog_states - 1)), 2'($urandom_range(3)));
      repeat ($urandom_range(0, 5))
         wr_tape(6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(8)),
                 pick_char());
      n_run = $urandom_range(4, 30);
      stop = 1'b0;
      for (k = 0; k < n_run && !stop; k++) begin
         r = $urandom_range(99);
         if (r < 10) begin
            rd_tape(6'(($urandom_range(1) == 0) ? $urandom_range(63) : $urandom_range(12)));
         end else if (r < 15) begin
            send_noise();
         end else begin
            safe_step();
            if (halt_bit && $urandom_range(1) == 0) stop = 1'b1;
         end
      end
   endtask

   // phases of random programs, each under its own register setting
   task automatic test_random_programs();
      int         phase;
      int         phase_end;
      logic [2:0] cnt;
      logic [7:0] blank;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         blank = 8'($urandom_range(255));
         case (phase % 8)
            0: cnt = 3'd4;
            1: begin cnt = 3'd1; blank = 8'h00; end
            2: begin cnt = 3'd7; blank = 8'hFF; end
            3: cnt = 3'd0;
            4: cnt = 3'd3;
            5: cnt = 3'd2;
            6: cnt = 3'd5;
            default: cnt = 3'd6;
         endcase
         set_registers(cnt, blank);
         // one phase runs with both sides always ready
         steady = (phase == 2);
         phase_end = items_sent + ((cnt == 0) ? 30 : 90);
         if (phase_end > ITEM_TARGET) phase_end = ITEM_TARGET;
         while (items_sent < phase_end) begin
            if ($urandom_range(9) < 8) run_program();
            else send_noise();
         end
         phase++;
      end
      steady = 1'b0;
   endtask

   initial begin
      image_reset();
      foreach (prog_alpha[i]) prog_alpha[i] = 8'($urandom_range(255));
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_on();
      test_unknown_symbol();
      test_halt_and_left_edge();
      test_tape_end();
      test_random_programs();
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      $display("run covered %0d commands, %0d of them steps, over %0d register settings",
               items_sent, n_steps, n_settings);
      $display("machine stops seen: %0d rule halts, %0d unknown symbols, %0d off-tape moves",
               n_rule_halts, n_symbol_faults, n_edge_faults);
      if (mismatches == 0 && status_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT);
      $display("%0t run did not finish in time", $time);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
